/* design/bps_pkg.sv */
// Package for the byte pattern substituter: transfer types, operation codes and constants.
`default_nettype none

package bps_pkg;

    // Operation codes carried in the op field of an input transfer.
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // Replacement code that deletes a completed match.
    localparam logic [6:0] DELETE_CODE = 7'd127;

    // Replacement code that keeps only the first byte of the match.
    localparam logic [6:0] KEEP_FIRST_CODE = 7'd0;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data_byte;
        logic [5:0]  entry_index;
        logic [2:0]  entry_length;
        logic [31:0] entry_bytes;
        logic [6:0]  entry_replacement;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

/* design/byte_pattern_substituter_top.sv */
// Top level of the byte pattern substituter: pattern table, match logic and result queue.
`default_nettype none

// An accepted item is held in the input register and judged there; its results are
// written to the result queue, whose head drives the result channel.
// Throughput: one item per cycle unless the item channel stalls. A mismatch releases up to
// MAX_PATTERN_LEN bytes at once; these drain at one per cycle while result_stall is low,
// and the item channel stalls while the queue has fewer than MAX_PATTERN_LEN free slots.
// Reset clears every pattern valid bit, the held byte count and the result queue.
module byte_pattern_substituter_top #(
    parameter int PATTERN_ENTRIES = 64,
    parameter int MAX_PATTERN_LEN = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,

    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire bps_pkg::item_t  item,

    output logic                 result_valid,
    input  wire logic            result_stall,
    output bps_pkg::result_t     result
);

    // Derived sizes. The held-byte store keeps at most one byte fewer than the longest
    // pattern, since a full-length match always completes.
    localparam int IDX_W       = (PATTERN_ENTRIES > 1) ? $clog2(PATTERN_ENTRIES) : 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PD_W        = 8 * MAX_PATTERN_LEN;
    localparam int HELD_SLOTS  = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;
    localparam int CNT_W       = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int RC_W        = $clog2(MAX_PATTERN_LEN + 1);
    localparam int QD          = 2 * MAX_PATTERN_LEN;
    localparam int QC_W        = $clog2(QD + 1);

    // Pattern table. Every entry has its own comparator, so the entries are plain
    // registers read at fixed places. Only the valid bits are reset.
    logic                      pat_valid_reg [PATTERN_ENTRIES];
    logic [LEN_W-1:0]          pat_len_reg   [PATTERN_ENTRIES];
    logic [PD_W-1:0]           pat_data_reg  [PATTERN_ENTRIES];
    logic [6:0]                pat_repl_reg  [PATTERN_ENTRIES];

    // Input register.
    logic                      busy_reg;
    logic                      busy_next;
    bps_pkg::item_t            cur_reg;

    // Bytes of a partly matched pattern that are held back.
    logic [7:0]                held_reg [HELD_SLOTS];
    logic [7:0]                held_next [HELD_SLOTS];
    logic [CNT_W-1:0]          held_count_reg;
    logic [CNT_W-1:0]          held_count_next;

    // Result queue: slot 0 is the head and always drives the result port.
    bps_pkg::result_t          queue_reg [QD];
    bps_pkg::result_t          queue_next [QD];
    logic [QC_W-1:0]           queue_count_reg;
    logic [QC_W-1:0]           queue_count_next;

    logic                      accept;
    logic                      proceed;
    logic                      pop;

    // Match evaluation.
    logic [7:0]                seq [MAX_PATTERN_LEN];
    logic                      any_prefix;
    logic                      any_longer;
    logic                      any_exact;
    logic [6:0]                repl;
    logic [7:0]                res_byte [MAX_PATTERN_LEN];
    logic [RC_W-1:0]           res_cnt;
    logic [RC_W-1:0]           push_cnt;
    logic [QC_W-1:0]           base;

    logic                      load_hit;
    logic [IDX_W-1:0]          load_idx;
    logic [LEN_W-1:0]          load_len;

    // ------------------------------------------------------------------------
    // Handshakes. The held item moves on only when the queue can take the largest
    // possible burst of results, so no result is ever dropped.
    // ------------------------------------------------------------------------
    assign proceed    = busy_reg && (int'(queue_count_reg) <= QD - MAX_PATTERN_LEN);
    assign item_stall = busy_reg && !proceed;
    assign accept     = item_valid && !item_stall;

    assign result_valid = (queue_count_reg != '0);
    assign result       = queue_reg[0];
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (proceed)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= item;
        end
    end

    // ------------------------------------------------------------------------
    // Table loads. A slot beyond the table is ignored, a length above the longest
    // pattern is saturated and a zero length disables the slot.
    // ------------------------------------------------------------------------
    assign load_hit = proceed && (cur_reg.op == bps_pkg::OP_LOAD)
                   && (int'(cur_reg.entry_index) < PATTERN_ENTRIES);
    assign load_idx = IDX_W'(cur_reg.entry_index);
    assign load_len = (int'(cur_reg.entry_length) > MAX_PATTERN_LEN)
                    ? LEN_W'(MAX_PATTERN_LEN) : LEN_W'(cur_reg.entry_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_ENTRIES; i++)
            begin
                pat_valid_reg[i] <= 1'b0;
            end
        end
        else if (load_hit)
        begin
            pat_valid_reg[load_idx] <= (cur_reg.entry_length != '0);
        end
    end

    // Pattern bytes beyond the length are never compared, so they are stored unmasked.
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            pat_len_reg[load_idx]  <= load_len;
            pat_data_reg[load_idx] <= PD_W'(cur_reg.entry_bytes);
            pat_repl_reg[load_idx] <= cur_reg.entry_replacement;
        end
    end

    // ------------------------------------------------------------------------
    // Match evaluation. The candidate sequence is the held bytes followed by the
    // current byte; every table entry checks it in parallel.
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN_LEN; j++)
        begin
            seq[j] = cur_reg.data_byte;
        end
        for (int j = 0; j < HELD_SLOTS; j++)
        begin
            if (j < int'(held_count_reg))
            begin
                seq[j] = held_reg[j];
            end
        end
    end

    always_comb
    begin
        logic hit;
        int   n;
        n          = int'(held_count_reg) + 1;
        any_prefix = 1'b0;
        any_longer = 1'b0;
        any_exact  = 1'b0;
        repl       = '0;
        // Scanned from the top so that the lowest matching slot has the last word.
        for (int i = PATTERN_ENTRIES - 1; i >= 0; i--)
        begin
            hit = pat_valid_reg[i] && (int'(pat_len_reg[i]) >= n);
            for (int j = 0; j < MAX_PATTERN_LEN; j++)
            begin
                if (j < n && pat_data_reg[i][8*j +: 8] != seq[j])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                any_prefix = 1'b1;
                if (int'(pat_len_reg[i]) > n)
                begin
                    any_longer = 1'b1;
                end
                else
                begin
                    any_exact = 1'b1;
                    repl      = pat_repl_reg[i];
                end
            end
        end
    end

    // Results and the next held state of the item in the input register.
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN_LEN; j++)
        begin
            res_byte[j] = seq[j];
        end
        for (int j = 0; j < HELD_SLOTS; j++)
        begin
            held_next[j] = held_reg[j];
        end
        res_cnt         = '0;
        held_count_next = held_count_reg;

        case (cur_reg.op)
            bps_pkg::OP_BYTE:
            begin
                if (!any_prefix)
                begin
                    // Mismatch: held bytes and the current byte go out unchanged.
                    res_cnt         = RC_W'(held_count_reg) + RC_W'(1);
                    held_count_next = '0;
                end
                else if (any_longer || !any_exact)
                begin
                    for (int j = 0; j < HELD_SLOTS; j++)
                    begin
                        if (j == int'(held_count_reg))
                        begin
                            held_next[j] = cur_reg.data_byte;
                        end
                    end
                    held_count_next = held_count_reg + CNT_W'(1);
                end
                else
                begin
                    held_count_next = '0;
                    if (repl != bps_pkg::DELETE_CODE)
                    begin
                        res_cnt = RC_W'(1);
                        if (repl != bps_pkg::KEEP_FIRST_CODE)
                        begin
                            res_byte[0] = {1'b0, repl};
                        end
                    end
                end
            end
            bps_pkg::OP_FLUSH:
            begin
                res_cnt         = RC_W'(held_count_reg);
                held_count_next = '0;
            end
            default:
            begin
                res_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
        end
        else if (proceed)
        begin
            held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed)
        begin
            for (int j = 0; j < HELD_SLOTS; j++)
            begin
                held_reg[j] <= held_next[j];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result queue. The head shifts down on a transfer out, and the new results of the
    // current item are written behind the entries that remain.
    // ------------------------------------------------------------------------
    assign push_cnt = proceed ? res_cnt : '0;
    assign base     = queue_count_reg - QC_W'(pop);

    always_comb
    begin
        int rel;
        for (int k = 0; k < QD; k++)
        begin
            queue_next[k] = queue_reg[k];
            if (pop && k < QD - 1)
            begin
                queue_next[k] = queue_reg[k + 1];
            end
            rel = k - int'(base);
            if (rel >= 0 && rel < int'(push_cnt))
            begin
                queue_next[k].out_byte = res_byte[rel];
                queue_next[k].last     = (rel == int'(push_cnt) - 1);
            end
        end
        queue_count_next = base + QC_W'(push_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_count_reg <= '0;
        end
        else
        begin
            queue_count_reg <= queue_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QD; k++)
        begin
            queue_reg[k] <= queue_next[k];
        end
    end

endmodule

`default_nettype wire
